>>> design/four_level_page_table_manager_defines.svh
// Assertion macros used by the page-table manager top-level design file.
`ifndef FOUR_LEVEL_PAGE_TABLE_MANAGER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_MANAGER_DEFINES_SVH

`ifndef ASSERT_OFF
// pre implies post in the same cycle
`define FLTM_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("page table manager check failed");
// condition holds on every cycle out of reset
`define FLTM_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("page table manager invariant failed");
`else
`define FLTM_ASSERT_IMP(name, clk, rst, pre, post)
`define FLTM_ASSERT_ALWAYS(name, clk, rst, cond)
`endif

`endif

>>> design/fltm_pkg.sv
// Shared constants, opcodes and step record for the page-table manager.
package fltm_pkg;

   // geometry of the table store
   localparam int TABLE_FRAMES      = 16;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int LEVELS            = 4;
   localparam int FRAME_W           = $clog2(TABLE_FRAMES);
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int ADDR_W            = FRAME_W + IDX_W;
   localparam int STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;
   localparam int NFF_W             = $clog2(TABLE_FRAMES + 1);
   localparam int LEVEL_W           = $clog2(LEVELS);

   // entry and field widths
   localparam int ENTRY_W = 64;
   localparam int STORE_W = ENTRY_W + 1;   // entry plus allocation tag
   localparam int OFS_W   = 12;
   localparam int FLAG_W  = 12;
   localparam int VIRT_W  = 48;
   localparam int PHYS_W  = 52;
   localparam int OP_W    = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_MAP       = 2'd0;
   localparam logic [OP_W-1:0] OP_UNMAP     = 2'd1;
   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;

   // entry flag bits
   localparam logic [FLAG_W-1:0] PG_PRESENT  = 12'h001;
   localparam logic [FLAG_W-1:0] PG_WRITABLE = 12'h002;
   localparam logic [FLAG_W-1:0] PG_USER     = 12'h004;

   // what the entry unit decides for one table access
   typedef struct packed {
      logic                 wr_en;
      logic [ENTRY_W-1:0]   wr_data;
      logic                 wr_tag;
      logic                 descend;
      logic [FRAME_W-1:0]   next_frame;
      logic                 take_frame;
      logic                 finish;
      logic                 success;
      logic [PHYS_W-1:0]    translated;
   } fltm_step_type;

endpackage

>>> design/four_level_page_table_manager.sv
// Four-level page-table manager: one memory port walked by a small sequencer.
// Walk: each level passes through a read state and an evaluate state; when the walk
//   ends, or straight from idle for an unknown op, a done state sets rsp_tvalid.
// Throughput: one request in flight; how soon a new one is taken is set by the walk
//   depth on the single table port and by rsp_tready. Reset: synchronous; a clearing
//   pass zeroes the 8192 store entries, req_tready low; csr writes taken meanwhile.
`include "four_level_page_table_manager_defines.svh"

module four_level_page_table_manager (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [3:0]   csr_wr_data,   // root_frame
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0], virt_addr[49:2], phys_addr[101:50], page_flags[113:102], zero pad
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // success[0], translated[52:1], zero pad
   output logic [55:0]  rsp_tdata
);
   import fltm_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam int REQ_VA_LSB = OP_W;
   localparam int REQ_PA_LSB = REQ_VA_LSB + VIRT_W;
   localparam int REQ_FL_LSB = REQ_PA_LSB + PHYS_W;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [FRAME_W-1:0]  root_ff;
   logic [NFF_W-1:0]    nff_ff, nff_in;
   logic [TABLE_FRAMES-1:0] alloc_ff, alloc_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [VIRT_W-1:0]   va_ff, va_in;
   logic [PHYS_W-1:0]   pa_ff, pa_in;
   logic [FLAG_W-1:0]   flags_ff, flags_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic                ok_ff, ok_in;
   logic [PHYS_W-1:0]   tr_ff, tr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [55:0]         rsp_data_ff, rsp_data_in;

   logic                req_beat;
   logic                root_ok;
   logic [IDX_W-1:0]    level_idx;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_wr_en;
   logic [STORE_W-1:0]  mem_wr_data;
   logic [STORE_W-1:0]  mem_rd_data;
   logic                cur_tag;
   logic [ENTRY_W-1:0]  cur_entry;
   fltm_step_type       step;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign root_ok    = NFF_W'(root_ff) < NFF_W'(TABLE_FRAMES);

   // table address: frame plus the 9-bit index of the current level
   assign level_idx = va_ff[OFS_W + IDX_W*(LEVELS-1-int'(level_ff)) +: IDX_W];
   assign mem_addr  = (state_ff == ST_CLEAR) ? clr_addr_ff : {frame_ff, level_idx};

   // entries written before their frame was last handed out read as zero
   assign cur_tag   = alloc_ff[frame_ff];
   assign cur_entry = (mem_rd_data[STORE_W-1] == cur_tag) ? mem_rd_data[ENTRY_W-1:0] : '0;

   assign mem_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_EVAL && step.wr_en);
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : {step.wr_tag, step.wr_data};

   fltm_table_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   fltm_entry_unit u_entry (
      .op         (op_ff),
      .last_level (level_ff == LEVEL_W'(LEVELS-1)),
      .entry      (cur_entry),
      .flags      (flags_ff),
      .phys_addr  (pa_ff),
      .virt_ofs   (va_ff[OFS_W-1:0]),
      .next_free  (nff_ff),
      .cur_frame  (frame_ff),
      .cur_tag    (cur_tag),
      .step       (step)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      nff_in       = nff_ff;
      alloc_in     = alloc_ff;
      op_in        = op_ff;
      va_in        = va_ff;
      pa_in        = pa_ff;
      flags_in     = flags_ff;
      level_in     = level_ff;
      frame_in     = frame_ff;
      ok_in        = ok_ff;
      tr_in        = tr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(STORE_DEPTH-1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               op_in    = req_tdata[OP_W-1:0];
               va_in    = req_tdata[REQ_VA_LSB +: VIRT_W];
               pa_in    = req_tdata[REQ_PA_LSB +: PHYS_W];
               flags_in = req_tdata[REQ_FL_LSB +: FLAG_W];
               level_in = '0;
               frame_in = root_ff;
               ok_in    = 1'b0;
               tr_in    = '0;
               if (root_ok && (req_tdata[OP_W-1:0] == OP_MAP ||
                               req_tdata[OP_W-1:0] == OP_UNMAP ||
                               req_tdata[OP_W-1:0] == OP_TRANSLATE)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (step.take_frame) begin
               nff_in = nff_ff + 1'b1;
               alloc_in[step.next_frame] = 1'b1;
            end
            if (step.descend) begin
               frame_in = step.next_frame;
               level_in = level_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               ok_in    = step.success;
               tr_in    = step.translated;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, tr_ff, ok_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         nff_ff       <= NFF_W'(1);
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         nff_ff       <= nff_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            root_ff <= csr_wr_data;
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      va_ff       <= va_in;
      pa_ff       <= pa_in;
      flags_ff    <= flags_in;
      level_ff    <= level_in;
      frame_ff    <= frame_in;
      ok_ff       <= ok_in;
      tr_ff       <= tr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // allocator never runs past the store
   `FLTM_ASSERT_ALWAYS(a_nff_bound, clock, reset, nff_ff <= NFF_W'(TABLE_FRAMES))
   // one tag flip per frame handed out, and frame zero is never handed out
   `FLTM_ASSERT_ALWAYS(a_alloc_count, clock, reset, $countones(alloc_ff) == 32'(nff_ff) - 1)
   `FLTM_ASSERT_ALWAYS(a_frame0_kept, clock, reset, alloc_ff[0] == 1'b0)
   // a fresh frame is only taken while walking a directory level
   `FLTM_ASSERT_IMP(a_take_dir, clock, reset, state_ff == ST_EVAL && step.take_frame,
                    level_ff != LEVEL_W'(LEVELS-1))

endmodule

>>> design/fltm_table_ram.sv
// Single-port table store with registered read data.
module fltm_table_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [fltm_pkg::ADDR_W-1:0]  addr,
   input  logic [fltm_pkg::STORE_W-1:0] wr_data,
   output logic [fltm_pkg::STORE_W-1:0] rd_data
);
   import fltm_pkg::*;

   logic [STORE_W-1:0] mem [STORE_DEPTH];
   logic [STORE_W-1:0] rd_data_ff;

   // write port and read-first read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/fltm_entry_unit.sv
// Shared entry unit: judges one table entry and builds the write-back for it.
module fltm_entry_unit (
   input  logic [fltm_pkg::OP_W-1:0]    op,
   input  logic                         last_level,
   input  logic [fltm_pkg::ENTRY_W-1:0] entry,
   input  logic [fltm_pkg::FLAG_W-1:0]  flags,
   input  logic [fltm_pkg::PHYS_W-1:0]  phys_addr,
   input  logic [fltm_pkg::OFS_W-1:0]   virt_ofs,
   input  logic [fltm_pkg::NFF_W-1:0]   next_free,
   input  logic [fltm_pkg::FRAME_W-1:0] cur_frame,
   input  logic                         cur_tag,
   output fltm_pkg::fltm_step_type      step
);
   import fltm_pkg::*;

   logic               present;
   logic               ptr_ok;
   logic               out_of_frames;
   logic [FRAME_W-1:0] new_frame;
   logic [FRAME_W-1:0] ptr_frame;

   // entry decode
   assign present       = entry[0];
   assign ptr_frame     = entry[OFS_W +: FRAME_W];
   assign ptr_ok        = (entry[ENTRY_W-1:OFS_W+FRAME_W] == '0) &&
                          (NFF_W'(ptr_frame) < NFF_W'(TABLE_FRAMES));
   assign out_of_frames = next_free >= NFF_W'(TABLE_FRAMES);
   assign new_frame     = next_free[FRAME_W-1:0];

   always_comb begin
      step = '0;
      if (!last_level) begin
         // directory level
         if (present) begin
            if (op == OP_MAP && (flags & PG_USER) != '0) begin
               step.wr_en   = 1'b1;
               step.wr_data = entry | {{(ENTRY_W-FLAG_W){1'b0}}, PG_USER};
               step.wr_tag  = cur_tag;
            end
            if (ptr_ok) begin
               step.descend    = 1'b1;
               step.next_frame = ptr_frame;
            end else begin
               step.finish = 1'b1;
            end
         end else if (op == OP_MAP && !out_of_frames) begin
            // fresh frame; tags on it go stale, including the one being walked
            step.take_frame = 1'b1;
            step.wr_en      = 1'b1;
            step.wr_data    = {{(ENTRY_W-OFS_W-FRAME_W){1'b0}}, new_frame, {OFS_W{1'b0}}} |
                              {{(ENTRY_W-FLAG_W){1'b0}},
                               PG_PRESENT | PG_WRITABLE | (flags & PG_USER)};
            step.wr_tag     = cur_tag | (new_frame == cur_frame);
            step.descend    = 1'b1;
            step.next_frame = new_frame;
         end else begin
            step.finish = 1'b1;
         end
      end else begin
         // leaf level
         step.finish = 1'b1;
         case (op)
            OP_MAP: begin
               step.wr_en   = 1'b1;
               step.wr_data = {{(ENTRY_W-PHYS_W){1'b0}}, phys_addr[PHYS_W-1:OFS_W],
                               flags | PG_PRESENT};
               step.wr_tag  = cur_tag;
               step.success = 1'b1;
            end
            OP_UNMAP: begin
               if (present) begin
                  step.wr_en   = 1'b1;
                  step.wr_data = '0;
                  step.wr_tag  = cur_tag;
                  step.success = 1'b1;
               end
            end
            OP_TRANSLATE: begin
               if (present) begin
                  step.success    = 1'b1;
                  step.translated = {entry[PHYS_W-1:OFS_W], virt_ofs};
               end
            end
            default: begin
               step.success = 1'b0;
            end
         endcase
      end
   end

endmodule
